/* hw/rtl/velocity_toward_target_defines.svh */
// Assertion macros shared by the velocity_toward_target RTL.
`ifndef VELOCITY_TOWARD_TARGET_DEFINES_SVH
`define VELOCITY_TOWARD_TARGET_DEFINES_SVH
`ifndef SYNTHESIS
`define VTT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("velocity_toward_target assertion failed");
`define VTT_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("velocity_toward_target reset assertion failed");
`else
`define VTT_ASSERT(lbl, prop)
`define VTT_ASSERT_RST(lbl, prop)
`endif
`endif

/* hw/rtl/vtt_pkg.sv */
// Widths, constants and pipeline payload types for velocity_toward_target.
`timescale 1ns / 1ps
package vtt_pkg;
  localparam int FRAC_BITS = 8;
  localparam int COORD_W   = 12;
  localparam int POS_W     = 21;
  localparam int DIM_W     = 12;
  localparam int SPEED_W   = 16;
  localparam int VEL_W     = 17;
  localparam int GUARD     = 8;
  // Signed offset width and magnitude width.
  localparam int D_W       = 23;
  localparam int MAG_W     = D_W - 1;
  localparam int SQ_W      = 2 * MAG_W + 1;
  localparam int RAD_W0    = SQ_W + 2 * GUARD;
  localparam int RAD_W     = RAD_W0 + (RAD_W0 % 2);
  localparam int ROOT_W    = RAD_W / 2;
  localparam int REM_W     = ROOT_W + 3;
  localparam int PROD_W    = SPEED_W + MAG_W;
  localparam int NUM_W     = PROD_W + GUARD;
  localparam int Q_W       = SPEED_W;

  typedef struct packed {
    logic               special;
    logic [VEL_W-1:0]   sp_x;
    logic [VEL_W-1:0]   sp_y;
    logic               neg_x;
    logic               neg_y;
    logic [SPEED_W-1:0] spd;
  } side_t;

  typedef struct packed {
    side_t            side;
    logic [NUM_W-1:0] num_x;
    logic [NUM_W-1:0] num_y;
  } root_pl_t;
endpackage

/* hw/rtl/vtt_ifs.sv */
// Handshake channel interfaces for the target request and velocity result.
`timescale 1ns / 1ps
interface vtt_in_if;
  logic                           valid;
  logic                           ready;
  logic [vtt_pkg::COORD_W-1:0]    target_x;
  logic [vtt_pkg::COORD_W-1:0]    target_y;
  logic signed [vtt_pkg::POS_W-1:0] pos_x;
  logic signed [vtt_pkg::POS_W-1:0] pos_y;
  logic [vtt_pkg::DIM_W-1:0]      box_width;
  logic [vtt_pkg::DIM_W-1:0]      box_height;
  logic [vtt_pkg::SPEED_W-1:0]    move_speed;
  modport src (output valid, target_x, target_y, pos_x, pos_y, box_width, box_height,
               move_speed, input ready);
  modport sink (input valid, target_x, target_y, pos_x, pos_y, box_width, box_height,
                move_speed, output ready);
endinterface

interface vtt_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [vtt_pkg::VEL_W-1:0] vel_x;
  logic signed [vtt_pkg::VEL_W-1:0] vel_y;
  modport src (output valid, vel_x, vel_y, input ready);
  modport sink (input valid, vel_x, vel_y, output ready);
endinterface

/* hw/rtl/vtt_front.sv */
// Front stages: offsets, magnitudes, squares, products and the radicand.
`timescale 1ns / 1ps
module vtt_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  logic                               in_valid,
  input  logic [vtt_pkg::COORD_W-1:0]        target_x,
  input  logic [vtt_pkg::COORD_W-1:0]        target_y,
  input  logic signed [vtt_pkg::POS_W-1:0]   pos_x,
  input  logic signed [vtt_pkg::POS_W-1:0]   pos_y,
  input  logic [vtt_pkg::DIM_W-1:0]          box_width,
  input  logic [vtt_pkg::DIM_W-1:0]          box_height,
  input  logic [vtt_pkg::SPEED_W-1:0]        move_speed,
  output logic                               valid,
  output logic [vtt_pkg::RAD_W-1:0]          rad,
  output vtt_pkg::root_pl_t                  pl
);
  localparam int D_W = vtt_pkg::D_W;
  localparam int MAG_W = vtt_pkg::MAG_W;
  localparam int FB = vtt_pkg::FRAC_BITS;

  logic [D_W-1:0] tx_f, ty_f, px_f, py_f, hw_f, hh_f, dx_c, dy_c;
  logic [D_W-1:0] dx1, dy1;
  logic [vtt_pkg::SPEED_W-1:0] spd1;
  logic v1;

  logic [D_W-1:0] absx_c, absy_c;
  logic zx_c, zy_c;
  vtt_pkg::side_t side_c;
  logic [vtt_pkg::VEL_W-1:0] spd_pos, spd_neg;
  logic [MAG_W-1:0] ax2, ay2;
  vtt_pkg::side_t side2;
  logic v2;

  logic [2*MAG_W-1:0] sqx3, sqy3;
  logic [vtt_pkg::PROD_W-1:0] prx3, pry3;
  vtt_pkg::side_t side3;
  logic v3;

  assign tx_f = D_W'({target_x, FB'(0)});
  assign ty_f = D_W'({target_y, FB'(0)});
  assign px_f = {{(D_W - vtt_pkg::POS_W){pos_x[vtt_pkg::POS_W-1]}}, pos_x};
  assign py_f = {{(D_W - vtt_pkg::POS_W){pos_y[vtt_pkg::POS_W-1]}}, pos_y};
  assign hw_f = D_W'({box_width, (FB - 1)'(0)});
  assign hh_f = D_W'({box_height, (FB - 1)'(0)});
  assign dx_c = tx_f - px_f - hw_f;
  assign dy_c = ty_f - py_f - hh_f;

  always_ff @(posedge clk) begin
    if (en) begin
      dx1  <= dx_c;
      dy1  <= dy_c;
      spd1 <= move_speed;
    end
  end

  assign absx_c  = dx1[D_W-1] ? (~dx1 + D_W'(1)) : dx1;
  assign absy_c  = dy1[D_W-1] ? (~dy1 + D_W'(1)) : dy1;
  assign zx_c    = (dx1 == '0);
  assign zy_c    = (dy1 == '0);
  assign spd_pos = vtt_pkg::VEL_W'(spd1);
  assign spd_neg = vtt_pkg::VEL_W'(0) - spd_pos;

  // An axis-aligned offset bypasses the root and divide; both zero points up.
  always_comb begin
    side_c.special = zx_c | zy_c;
    side_c.neg_x   = dx1[D_W-1];
    side_c.neg_y   = dy1[D_W-1];
    side_c.spd     = spd1;
    side_c.sp_x    = '0;
    side_c.sp_y    = '0;
    if (zx_c) begin
      side_c.sp_y = (!dy1[D_W-1] && !zy_c) ? spd_pos : spd_neg;
    end else if (zy_c) begin
      side_c.sp_x = !dx1[D_W-1] ? spd_pos : spd_neg;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax2   <= absx_c[MAG_W-1:0];
      ay2   <= absy_c[MAG_W-1:0];
      side2 <= side_c;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqx3  <= ax2 * ax2;
      sqy3  <= ay2 * ay2;
      prx3  <= vtt_pkg::PROD_W'(side2.spd) * vtt_pkg::PROD_W'(ax2);
      pry3  <= vtt_pkg::PROD_W'(side2.spd) * vtt_pkg::PROD_W'(ay2);
      side3 <= side2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad <= vtt_pkg::RAD_W'(vtt_pkg::SQ_W'(sqx3) + vtt_pkg::SQ_W'(sqy3))
             << (2 * vtt_pkg::GUARD);
      pl.num_x <= vtt_pkg::NUM_W'(prx3) << vtt_pkg::GUARD;
      pl.num_y <= vtt_pkg::NUM_W'(pry3) << vtt_pkg::GUARD;
      pl.side  <= side3;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      valid <= v3;
    end
  end
endmodule

/* hw/rtl/vtt_sqrt.sv */
// Pipelined integer square root, one root bit per register stage.
`timescale 1ns / 1ps
module vtt_sqrt (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic [vtt_pkg::RAD_W-1:0]      in_rad,
  input  vtt_pkg::root_pl_t              in_pl,
  output logic                           valid,
  output logic [vtt_pkg::ROOT_W-1:0]     root,
  output logic [vtt_pkg::REM_W-1:0]      rem,
  output vtt_pkg::root_pl_t              pl
);
  localparam int N = vtt_pkg::ROOT_W;
  localparam int RW = vtt_pkg::REM_W;
  localparam int RDW = vtt_pkg::RAD_W;

  logic                 st_v    [0:N];
  logic [RDW-1:0]       st_rad  [0:N];
  logic [N-1:0]         st_root [0:N];
  logic [RW-1:0]        st_rem  [0:N];
  vtt_pkg::root_pl_t    st_pl   [0:N];

  assign st_v[0]    = in_valid;
  assign st_rad[0]  = in_rad;
  assign st_root[0] = '0;
  assign st_rem[0]  = '0;
  assign st_pl[0]   = in_pl;

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [RW-1:0] rem_sh, trial;
    logic ge;
    assign rem_sh = {st_rem[i][RW-3:0], st_rad[i][RDW-1 -: 2]};
    assign trial  = RW'({st_root[i], 2'b01});
    assign ge     = (rem_sh >= trial);
    always_ff @(posedge clk) begin
      if (en) begin
        st_rad[i+1]  <= st_rad[i] << 2;
        st_root[i+1] <= {st_root[i][N-2:0], ge};
        st_rem[i+1]  <= ge ? (rem_sh - trial) : rem_sh;
        st_pl[i+1]   <= st_pl[i];
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        st_v[i+1] <= 1'b0;
      end else if (en) begin
        st_v[i+1] <= st_v[i];
      end
    end
  end

  assign valid = st_v[N];
  assign root  = st_root[N];
  assign rem   = st_rem[N];
  assign pl    = st_pl[N];
endmodule

/* hw/rtl/vtt_div.sv */
// Pipelined restoring divider for both axes, one quotient bit per stage.
`timescale 1ns / 1ps
module vtt_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic [vtt_pkg::ROOT_W-1:0]     in_len,
  input  vtt_pkg::root_pl_t              in_pl,
  output logic                           valid,
  output logic [vtt_pkg::Q_W-1:0]        q_x,
  output logic [vtt_pkg::Q_W-1:0]        q_y,
  output logic [vtt_pkg::NUM_W-1:0]      rem_x,
  output logic [vtt_pkg::NUM_W-1:0]      rem_y,
  output logic [vtt_pkg::ROOT_W-1:0]     len,
  output vtt_pkg::side_t                 side
);
  localparam int N = vtt_pkg::Q_W;
  localparam int NW = vtt_pkg::NUM_W;

  logic                    st_v   [0:N];
  logic [NW-1:0]           st_rx  [0:N];
  logic [NW-1:0]           st_ry  [0:N];
  logic [N-1:0]            st_qx  [0:N];
  logic [N-1:0]            st_qy  [0:N];
  logic [vtt_pkg::ROOT_W-1:0] st_len [0:N];
  vtt_pkg::side_t          st_sd  [0:N];

  assign st_v[0]   = in_valid;
  assign st_rx[0]  = in_pl.num_x;
  assign st_ry[0]  = in_pl.num_y;
  assign st_qx[0]  = '0;
  assign st_qy[0]  = '0;
  assign st_len[0] = in_len;
  assign st_sd[0]  = in_pl.side;

  // The quotient never exceeds the speed, so it fits in the speed width.
  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [NW-1:0] dsh;
    logic gx, gy;
    assign dsh = NW'(st_len[k]) << (N - 1 - k);
    assign gx  = (st_rx[k] >= dsh);
    assign gy  = (st_ry[k] >= dsh);
    always_ff @(posedge clk) begin
      if (en) begin
        st_rx[k+1]  <= gx ? (st_rx[k] - dsh) : st_rx[k];
        st_ry[k+1]  <= gy ? (st_ry[k] - dsh) : st_ry[k];
        st_qx[k+1]  <= {st_qx[k][N-2:0], gx};
        st_qy[k+1]  <= {st_qy[k][N-2:0], gy};
        st_len[k+1] <= st_len[k];
        st_sd[k+1]  <= st_sd[k];
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        st_v[k+1] <= 1'b0;
      end else if (en) begin
        st_v[k+1] <= st_v[k];
      end
    end
  end

  assign valid = st_v[N];
  assign q_x   = st_qx[N];
  assign q_y   = st_qy[N];
  assign rem_x = st_rx[N];
  assign rem_y = st_ry[N];
  assign len   = st_len[N];
  assign side  = st_sd[N];
endmodule

/* hw/rtl/velocity_toward_target.sv */
// Top level: velocity from a box center toward a target pixel at a given speed.
// Fully pipelined: one beat is accepted every cycle while the output is not
// stalled. Each result passes 4 front stages for offsets, squares and
// products, 31 square-root stages that each settle one root bit, 16 divider
// stages that each settle one quotient bit of both axes, and the output
// register. When the output beat is not taken, the whole pipeline holds.
`timescale 1ns / 1ps
`include "velocity_toward_target_defines.svh"
module velocity_toward_target (
  input  logic       clk,
  input  logic       rst,
  vtt_in_if.sink     target,
  vtt_out_if.src     velocity
);
  localparam int VW = vtt_pkg::VEL_W;

  logic en;
  logic fv, sv, dv;
  logic [vtt_pkg::RAD_W-1:0] frad;
  vtt_pkg::root_pl_t fpl, spl;
  logic [vtt_pkg::ROOT_W-1:0] sroot, dlen;
  logic [vtt_pkg::REM_W-1:0] srem, root2;
  logic [vtt_pkg::Q_W-1:0] dqx, dqy;
  logic [vtt_pkg::NUM_W-1:0] drx, dry;
  vtt_pkg::side_t dside;
  logic [VW-1:0] qx_w, qy_w, vx_c, vy_c;
  logic out_valid;
  logic [VW-1:0] vel_x, vel_y;

  assign en = !out_valid || velocity.ready;
  assign target.ready = en;

  vtt_front u_front (
    .clk(clk), .rst(rst), .en(en), .in_valid(target.valid),
    .target_x(target.target_x), .target_y(target.target_y),
    .pos_x(target.pos_x), .pos_y(target.pos_y),
    .box_width(target.box_width), .box_height(target.box_height),
    .move_speed(target.move_speed),
    .valid(fv), .rad(frad), .pl(fpl)
  );

  vtt_sqrt u_sqrt (
    .clk(clk), .rst(rst), .en(en), .in_valid(fv), .in_rad(frad), .in_pl(fpl),
    .valid(sv), .root(sroot), .rem(srem), .pl(spl)
  );

  vtt_div u_div (
    .clk(clk), .rst(rst), .en(en), .in_valid(sv), .in_len(sroot), .in_pl(spl),
    .valid(dv), .q_x(dqx), .q_y(dqy), .rem_x(drx), .rem_y(dry),
    .len(dlen), .side(dside)
  );

  assign qx_w = VW'(dqx);
  assign qy_w = VW'(dqy);
  assign vx_c = dside.special ? dside.sp_x : (dside.neg_x ? (VW'(0) - qx_w) : qx_w);
  assign vy_c = dside.special ? dside.sp_y : (dside.neg_y ? (VW'(0) - qy_w) : qy_w);

  always_ff @(posedge clk) begin
    if (en) begin
      vel_x <= vx_c;
      vel_y <= vy_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv;
    end
  end

  assign velocity.valid = out_valid;
  assign velocity.vel_x = vel_x;
  assign velocity.vel_y = vel_y;

  assign root2 = vtt_pkg::REM_W'({sroot, 1'b0});

  `VTT_ASSERT_RST(a_reset_empty, rst |=> !velocity.valid)
  `VTT_ASSERT(a_root_exact, sv |-> (srem <= root2))
  `VTT_ASSERT(a_div_rem, (dv && !dside.special) |-> ((drx < vtt_pkg::NUM_W'(dlen)) && (dry < vtt_pkg::NUM_W'(dlen))))
  `VTT_ASSERT(a_mag_bound, (dv && !dside.special) |-> ((dqx <= dside.spd) && (dqy <= dside.spd)))
  `VTT_ASSERT(a_axis_aligned, (dv && dside.special) |-> ((dside.sp_x == '0) || (dside.sp_y == '0)))
endmodule
